/* rtl/ctc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants for the color threshold centroid block
// Register indexes, reset values, the per-word classification record and the
// back-end state type.
// ----------------------------------------------------------------------------
package ctc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LUMA_FLOOR   = 3'd0,
    CFG_LUMA_CEILING = 3'd1,
    CFG_CHROMA_FLOOR = 3'd2,
    CFG_DEBUG_ENABLE = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic [7:0]  LUMA_FLOOR_RST   = 8'd0;
  localparam logic [7:0]  LUMA_CEILING_RST = 8'd100;
  localparam logic [7:0]  CHROMA_FLOOR_RST = 8'd160;
  localparam logic        DEBUG_RST        = 1'b0;
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1920;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;

  // Pixel and result field widths
  localparam int          PIX_W     = 16;
  localparam int          CENT_W    = 11;
  localparam int          CNT_OUT_W = 22;
  localparam logic [15:0] MISS_WORD = 16'h00FF;

  // One classified word as it travels from front end to back end
  typedef struct packed {
    logic [PIX_W-1:0] first_word;
    logic [PIX_W-1:0] second_word;
    logic             debug;
    logic             hit;
    logic             done;
  } pix_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } back_state_e;

endpackage

/* rtl/ctc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_queue: two-entry queue between front end and back end
// Lets the front end keep accepting words while the back end waits on the
// output or on the frame-end divide.
// ----------------------------------------------------------------------------
module ctc_queue #(
  parameter int DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              pop_i
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/ctc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_front: configuration registers, pixel classification and frame totals
// Takes one pixel pair per cycle while the queue has room, tracks column and
// row, sums the matched column, row and count, and pushes one record per word.
// ----------------------------------------------------------------------------
module ctc_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int CW         = 11,
  parameter int RW         = 11,
  parameter int HW         = 22,
  parameter int XW         = 33,
  parameter int YW         = 33
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ctc_pkg::PIX_W-1:0]            first_word_i,
  input  logic [ctc_pkg::PIX_W-1:0]            second_word_i,
  // queue side
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output ctc_pkg::pix_t                        q_pix_o,
  output logic [XW-1:0]                        q_xsum_o,
  output logic [YW-1:0]                        q_ysum_o,
  output logic [HW-1:0]                        q_hits_o
);

  // comparison widths hold both the 12-bit register and the maximum size
  localparam int EW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int GW = (RW + 1 > 12) ? RW + 1 : 12;
  localparam logic [EW-1:0] W_MAX = EW'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam logic [GW-1:0] H_MAX = GW'(MAX_HEIGHT);

  // configuration registers
  logic [7:0]  luma_floor_q;
  logic [7:0]  luma_ceiling_q;
  logic [7:0]  chroma_floor_q;
  logic        debug_q;
  logic [11:0] frame_width_q;
  logic [11:0] frame_height_q;

  // frame state
  logic [CW-1:0] column_q, column_d;
  logic [RW-1:0] row_q, row_d;
  logic [XW-1:0] xsum_q, xsum_d;
  logic [YW-1:0] ysum_q, ysum_d;
  logic [HW-1:0] hits_q, hits_d;

  logic [EW-1:0] width_even;
  logic [EW-1:0] eff_width;
  logic [GW-1:0] height_ext;
  logic [GW-1:0] eff_height;
  logic [7:0]    luma;
  logic [7:0]    chroma;
  logic          hit;
  logic          row_end;
  logic          done;
  logic          push;
  logic [XW-1:0] xsum_new;
  logic [YW-1:0] ysum_new;
  logic [HW-1:0] hits_new;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_floor_q   <= ctc_pkg::LUMA_FLOOR_RST;
      luma_ceiling_q <= ctc_pkg::LUMA_CEILING_RST;
      chroma_floor_q <= ctc_pkg::CHROMA_FLOOR_RST;
      debug_q        <= ctc_pkg::DEBUG_RST;
      frame_width_q  <= ctc_pkg::FRAME_WIDTH_RST;
      frame_height_q <= ctc_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (ctc_pkg::cfg_idx_e'(cfg_index_i))
        ctc_pkg::CFG_LUMA_FLOOR:   luma_floor_q   <= cfg_wdata_i[7:0];
        ctc_pkg::CFG_LUMA_CEILING: luma_ceiling_q <= cfg_wdata_i[7:0];
        ctc_pkg::CFG_CHROMA_FLOOR: chroma_floor_q <= cfg_wdata_i[7:0];
        ctc_pkg::CFG_DEBUG_ENABLE: debug_q        <= cfg_wdata_i[0];
        ctc_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        ctc_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective frame size: even width clamped to [2, max], height to [1, max]
  always_comb begin
    width_even = EW'({frame_width_q[11:1], 1'b0});
    if (width_even < EW'(2)) begin
      eff_width = EW'(2);
    end else if (width_even > W_MAX) begin
      eff_width = W_MAX;
    end else begin
      eff_width = width_even;
    end
    height_ext = GW'(frame_height_q);
    if (height_ext == '0) begin
      eff_height = GW'(1);
    end else if (height_ext > H_MAX) begin
      eff_height = H_MAX;
    end else begin
      eff_height = height_ext;
    end
  end

  // classify the pair and find row and frame ends
  assign luma    = first_word_i[7:0];
  assign chroma  = second_word_i[15:8];
  assign hit     = (luma > luma_floor_q) && (luma < luma_ceiling_q) &&
                   (chroma > chroma_floor_q);
  assign row_end = ((EW + 1)'(column_q) + (EW + 1)'(2)) >= (EW + 1)'(eff_width);
  assign done    = row_end && (((GW + 1)'(row_q) + (GW + 1)'(1)) >= (GW + 1)'(eff_height));

  assign in_ready_o = !q_full_i;
  assign push       = in_valid_i && !q_full_i;

  // totals including this pair
  assign xsum_new = hit ? xsum_q + XW'(column_q) : xsum_q;
  assign ysum_new = hit ? ysum_q + YW'(row_q) : ysum_q;
  assign hits_new = hit ? hits_q + HW'(1) : hits_q;

  // position and total update
  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    xsum_d   = xsum_q;
    ysum_d   = ysum_q;
    hits_d   = hits_q;
    if (push) begin
      priority if (done) begin
        column_d = '0;
        row_d    = '0;
        xsum_d   = '0;
        ysum_d   = '0;
        hits_d   = '0;
      end else if (row_end) begin
        column_d = '0;
        row_d    = RW'(row_q + RW'(1));
        xsum_d   = xsum_new;
        ysum_d   = ysum_new;
        hits_d   = hits_new;
      end else begin
        column_d = CW'(column_q + CW'(2));
        xsum_d   = xsum_new;
        ysum_d   = ysum_new;
        hits_d   = hits_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      xsum_q   <= '0;
      ysum_q   <= '0;
      hits_q   <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
      xsum_q   <= xsum_d;
      ysum_q   <= ysum_d;
      hits_q   <= hits_d;
    end
  end

  // record for the back end
  assign q_push_o            = push;
  assign q_pix_o.first_word  = first_word_i;
  assign q_pix_o.second_word = second_word_i;
  assign q_pix_o.debug       = debug_q;
  assign q_pix_o.hit         = hit;
  assign q_pix_o.done        = done;
  assign q_xsum_o            = xsum_new;
  assign q_ysum_o            = ysum_new;
  assign q_hits_o            = hits_new;

endmodule

/* rtl/ctc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_div: restoring unsigned divider, one quotient bit per cycle
// busy_o drops when the quotient is ready.
// ----------------------------------------------------------------------------
module ctc_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one shift-subtract step
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quot_d = {quot_q[NUM_W-2:0], fits};
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= num_i;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

/* rtl/ctc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_back: result formatting, frame-end divide and output register
// Turns each queued record into one output word; on a frame end with matches
// it runs both centroid divides before the word goes out.
// ----------------------------------------------------------------------------
module ctc_back #(
  parameter int HW = 22,
  parameter int XW = 33,
  parameter int YW = 33
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // queue side
  input  logic                               q_valid_i,
  input  ctc_pkg::pix_t                      q_pix_i,
  input  logic [XW-1:0]                      q_xsum_i,
  input  logic [YW-1:0]                      q_ysum_i,
  input  logic [HW-1:0]                      q_hits_i,
  output logic                               q_pop_o,
  // output words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ctc_pkg::PIX_W-1:0]          out_first_o,
  output logic [ctc_pkg::PIX_W-1:0]          out_second_o,
  output logic                               write_valid_o,
  output logic                               pair_matched_o,
  output logic                               frame_done_o,
  output logic [ctc_pkg::CENT_W-1:0]         centroid_x_o,
  output logic [ctc_pkg::CENT_W-1:0]         centroid_y_o,
  output logic [ctc_pkg::CNT_OUT_W-1:0]      match_count_o
);

  ctc_pkg::back_state_e state_q, state_d;

  logic          slot_free;
  logic          div_start;
  logic          load_direct;
  logic          load_div;
  logic          out_valid_q, out_valid_d;
  logic          x_busy, y_busy;
  logic [XW-1:0] x_quot;
  logic [YW-1:0] y_quot;
  ctc_pkg::pix_t held_pix_q;
  logic [HW-1:0] held_hits_q;
  ctc_pkg::pix_t src;

  logic [ctc_pkg::PIX_W-1:0]     first_q, second_q;
  logic                          wvalid_q, matched_q, done_q;
  logic [ctc_pkg::CENT_W-1:0]    cx_q, cy_q;
  logic [ctc_pkg::CNT_OUT_W-1:0] count_q;

  // centroid dividers, run side by side
  ctc_div #(
    .NUM_W (XW),
    .DEN_W (HW)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (q_xsum_i),
    .den_i   (q_hits_i),
    .busy_o  (x_busy),
    .quot_o  (x_quot)
  );

  ctc_div #(
    .NUM_W (YW),
    .DEN_W (HW)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (q_ysum_i),
    .den_i   (q_hits_i),
    .busy_o  (y_busy),
    .quot_o  (y_quot)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    div_start   = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    unique case (state_q)
      ctc_pkg::BK_IDLE: begin
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          if (q_pix_i.done && (q_hits_i != '0)) begin
            div_start = 1'b1;
            state_d   = ctc_pkg::BK_DIV;
          end else begin
            load_direct = 1'b1;
          end
        end
      end
      ctc_pkg::BK_DIV: begin
        if (!x_busy && !y_busy && slot_free) begin
          load_div = 1'b1;
          state_d  = ctc_pkg::BK_IDLE;
        end
      end
      default: state_d = ctc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    if (load_direct || load_div) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctc_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // frame-end record held while dividing
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      held_pix_q  <= q_pix_i;
      held_hits_q <= q_hits_i;
    end
  end

  assign src = load_div ? held_pix_q : q_pix_i;

  // output register
  always_ff @(posedge clk_i) begin
    if (load_direct || load_div) begin
      first_q   <= src.debug ? (src.hit ? src.first_word : ctc_pkg::MISS_WORD) : '0;
      second_q  <= src.debug ? (src.hit ? src.second_word : ctc_pkg::MISS_WORD) : '0;
      wvalid_q  <= src.debug;
      matched_q <= src.hit;
      done_q    <= src.done;
      cx_q      <= load_div ? ctc_pkg::CENT_W'(x_quot) : '0;
      cy_q      <= load_div ? ctc_pkg::CENT_W'(y_quot) : '0;
      count_q   <= load_div ? ctc_pkg::CNT_OUT_W'(held_hits_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_first_o    = first_q;
  assign out_second_o   = second_q;
  assign write_valid_o  = wvalid_q;
  assign pair_matched_o = matched_q;
  assign frame_done_o   = done_q;
  assign centroid_x_o   = cx_q;
  assign centroid_y_o   = cy_q;
  assign match_count_o  = count_q;

endmodule

/* rtl/color_threshold_centroid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_threshold_centroid: color threshold match and blob centroid per frame
// Path: a word's record passes through the two-entry queue to the output register.
// Throughput: one pixel pair per cycle while the two-entry queue has room.
// Frame end with matches: the output word waits for the serial divide.
// Reset: async active low; registers take their defaults, totals clear.
// ----------------------------------------------------------------------------
module color_threshold_centroid #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ctc_pkg::PIX_W-1:0]          first_word_i,
  input  logic [ctc_pkg::PIX_W-1:0]          second_word_i,
  // output words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ctc_pkg::PIX_W-1:0]          out_first_o,
  output logic [ctc_pkg::PIX_W-1:0]          out_second_o,
  output logic                               write_valid_o,
  output logic                               pair_matched_o,
  output logic                               frame_done_o,
  output logic [ctc_pkg::CENT_W-1:0]         centroid_x_o,
  output logic [ctc_pkg::CENT_W-1:0]         centroid_y_o,
  output logic [ctc_pkg::CNT_OUT_W-1:0]      match_count_o
);

  // position, count and total widths
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW    = $clog2((MAX_WIDTH / 2) * MAX_HEIGHT + 1);
  localparam int XW    = CW + HW;
  localparam int YW    = RW + HW;
  localparam int PIX_T = $bits(ctc_pkg::pix_t);
  localparam int ENT_W = PIX_T + HW + YW + XW;

  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  ctc_pkg::pix_t      f_pix;
  logic [XW-1:0]      f_xsum;
  logic [YW-1:0]      f_ysum;
  logic [HW-1:0]      f_hits;
  logic [ENT_W-1:0]   q_wdata;
  logic [ENT_W-1:0]   q_rdata;
  ctc_pkg::pix_t      b_pix;
  logic [XW-1:0]      b_xsum;
  logic [YW-1:0]      b_ysum;
  logic [HW-1:0]      b_hits;

  ctc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW),
    .HW         (HW),
    .XW         (XW),
    .YW         (YW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_word_i  (first_word_i),
    .second_word_i (second_word_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_pix_o       (f_pix),
    .q_xsum_o      (f_xsum),
    .q_ysum_o      (f_ysum),
    .q_hits_o      (f_hits)
  );

  // pack and unpack queue records
  assign q_wdata = {f_pix, f_hits, f_ysum, f_xsum};
  assign b_pix   = ctc_pkg::pix_t'(q_rdata[ENT_W-1 -: PIX_T]);
  assign b_hits  = q_rdata[XW+YW +: HW];
  assign b_ysum  = q_rdata[XW +: YW];
  assign b_xsum  = q_rdata[XW-1:0];

  ctc_queue #(
    .DATA_W (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  ctc_back #(
    .HW (HW),
    .XW (XW),
    .YW (YW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pix_i        (b_pix),
    .q_xsum_i       (b_xsum),
    .q_ysum_i       (b_ysum),
    .q_hits_i       (b_hits),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_first_o    (out_first_o),
    .out_second_o   (out_second_o),
    .write_valid_o  (write_valid_o),
    .pair_matched_o (pair_matched_o),
    .frame_done_o   (frame_done_o),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .match_count_o  (match_count_o)
  );

`ifndef SYNTHESIS
  // frame results are zero on words that do not end a frame
  a_mid_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |->
      centroid_x_o == '0 && centroid_y_o == '0 && match_count_o == '0)
    else $error("frame results nonzero before frame end");

  // no matches gives a 0,0 centroid
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && match_count_o == '0 |->
      centroid_x_o == '0 && centroid_y_o == '0)
    else $error("centroid nonzero with no matches");

  // pixel outputs are zero with debug off, the miss word on a miss with debug on
  a_pixel_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!write_valid_o || !pair_matched_o) |->
      (!write_valid_o && out_first_o == '0 && out_second_o == '0) ||
      (write_valid_o && out_first_o == ctc_pkg::MISS_WORD &&
       out_second_o == ctc_pkg::MISS_WORD))
    else $error("pixel output not masked");

  // a matched word never reports zero matches at frame end
  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && pair_matched_o |-> match_count_o != '0)
    else $error("matched frame end reports no matches");
`endif

endmodule
